// ===== rtl/tsh_pkg.sv =====
// shared types, constants and trit helpers for the ternary sponge hash
package tsh_pkg;

  // width of the rate position carried in a command
  localparam int unsigned POS_W = 8;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [6:0] ROUND_COUNT_RESET = 7'd81;

  // two-bit trit codes: value & 3, so 2'b11 is -1 and 2'b10 is the table's 2
  localparam logic [1:0] TRIT_ZERO = 2'b00;
  localparam logic [1:0] TRIT_NEG = 2'b11;

  localparam logic [1:0] TRIT_TABLE [11] = '{
    2'b01, 2'b00, 2'b11, 2'b10, 2'b01, 2'b11,
    2'b00, 2'b10, 2'b11, 2'b01, 2'b00
  };

  typedef enum logic [1:0] {
    OP_ABSORB  = 2'd0,
    OP_SQUEEZE = 2'd1,
    OP_CLEAR   = 2'd2
  } op_e;

  typedef enum logic {
    CORE_RUN   = 1'b0,
    CORE_ROUND = 1'b1
  } core_state_e;

  typedef struct packed {
    op_e              op;
    logic [1:0]       trit;
    logic [POS_W-1:0] pos;
    logic             last;
  } cmd_t;

  // position after a number of steps of the alternating walk
  function automatic int walk_idx(int n, int half, int steps);
    int j;
    j = 0;
    for (int k = 0; k < steps; k++) begin
      if (j <= half) begin
        j = j + half;
      end else begin
        j = j - (half + 1);
      end
      if (j >= n) begin
        j = j - n;
      end
    end
    return j;
  endfunction

  function automatic int trit_value(logic [1:0] code);
    int v;
    v = (code == TRIT_NEG) ? -1 : int'(code);
    return v;
  endfunction

  // one output trit of a round from the pair of copied trits
  function automatic logic [1:0] mix_trit(logic [1:0] a, logic [1:0] b);
    int idx;
    idx = trit_value(a) + 4 * trit_value(b) + 5;
    if (idx < 0 || idx > 10) begin
      idx = 5;
    end
    return TRIT_TABLE[4'(idx)];
  endfunction

endpackage

// ===== rtl/ternary_sponge_hash.sv =====
// top level of the ternary sponge hash
// squeeze path: the item goes through the command queue into the output register
//   when the queue holds nothing older and no transform is running
// throughput: one item per cycle, held by a stalled output or a running transform
//   (at a block end or after the last rate trit), whose rounds run one per cycle
// reset: state trits, rate position, queue and output valid clear; round_count goes to 81
module ternary_sponge_hash #(
  parameter int unsigned STATE_TRITS = 729,
  parameter int unsigned RATE_TRITS  = 243
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [6:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        operation_i,
  input  logic signed [1:0] trit_in_i,
  input  logic              block_end_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic signed [1:0] trit_out_o
);
  import tsh_pkg::*;

  logic [6:0] round_count_q;
  logic       push, full, pop, empty;
  cmd_t       push_cmd, pop_cmd;
  logic [1:0] trit_code;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_count_q <= ROUND_COUNT_RESET;
    end else if (cfg_we_i) begin
      round_count_q <= cfg_data_i;
    end
  end

  assign in_ready_o = !full;

  tsh_front #(
    .RATE_TRITS(RATE_TRITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_valid_i && in_ready_o),
    .operation_i(operation_i),
    .trit_in_i  (trit_in_i),
    .block_end_i(block_end_i),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  tsh_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .pop_data_o (pop_cmd),
    .empty_o    (empty)
  );

  tsh_core #(
    .STATE_TRITS(STATE_TRITS),
    .RATE_TRITS (RATE_TRITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .round_count_i(round_count_q),
    .cmd_avail_i  (!empty),
    .cmd_i        (pop_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .trit_o       (trit_code)
  );

  assign trit_out_o = signed'(trit_code);

endmodule

// ===== rtl/tsh_front.sv =====
// front end: decodes items, tracks the rate position and builds commands
module tsh_front #(
  parameter int unsigned RATE_TRITS = 243
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [1:0]        operation_i,
  input  logic signed [1:0] trit_in_i,
  input  logic              block_end_i,
  output logic              push_o,
  output tsh_pkg::cmd_t     cmd_o
);
  import tsh_pkg::*;

  localparam int unsigned PosW = (RATE_TRITS > 1) ? $clog2(RATE_TRITS) : 1;

  logic [PosW-1:0] pos_q, pos_d;
  logic            last;

  assign last = block_end_i || (pos_q == PosW'(RATE_TRITS - 1));

  always_comb begin
    push_o    = 1'b0;
    pos_d     = pos_q;
    cmd_o.op   = OP_ABSORB;
    // -2 pattern saturates to -1
    cmd_o.trit = trit_in_i[1] ? TRIT_NEG : trit_in_i;
    cmd_o.pos  = POS_W'(pos_q);
    cmd_o.last = last;
    case (operation_i)
      OP_ABSORB, OP_SQUEEZE: begin
        cmd_o.op = op_e'(operation_i);
        push_o   = accept_i;
        if (accept_i) begin
          pos_d = last ? '0 : pos_q + 1'b1;
        end
      end
      OP_CLEAR: begin
        cmd_o.op   = OP_CLEAR;
        cmd_o.last = 1'b0;
        push_o     = accept_i;
        if (accept_i) begin
          pos_d = '0;
        end
      end
      default: begin
        // unused code: dropped
        push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// ===== rtl/tsh_queue.sv =====
// short command queue between front end and sponge core
module tsh_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tsh_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output tsh_pkg::cmd_t pop_data_o,
  output logic          empty_o
);
  import tsh_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o     = (count_q == CntW'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/tsh_core.sv =====
// sponge core: state array, absorb/squeeze/clear and one full round per cycle
module tsh_core #(
  parameter int unsigned STATE_TRITS = 729,
  parameter int unsigned RATE_TRITS  = 243
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [6:0]    round_count_i,
  input  logic          cmd_avail_i,
  input  tsh_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    trit_o
);
  import tsh_pkg::*;

  localparam int unsigned Half = STATE_TRITS / 2;
  localparam int unsigned IdxW = $clog2(STATE_TRITS);
  localparam int unsigned PosW = (RATE_TRITS > 1) ? $clog2(RATE_TRITS) : 1;

  core_state_e fsm_q, fsm_d;
  logic [6:0]  rounds_q, rounds_d;
  logic [1:0]  state_q [STATE_TRITS];
  logic [1:0]  state_d [STATE_TRITS];
  logic [1:0]  mixed [STATE_TRITS];
  logic        out_valid_q, out_valid_d;
  logic [1:0]  trit_q, trit_d;
  logic [IdxW-1:0] pos_idx;
  logic        out_free;

  // round network: every trit from a fixed pair along the walk
  for (genvar i = 0; i < STATE_TRITS; i++) begin : g_round
    localparam int unsigned JA = walk_idx(STATE_TRITS, Half, i);
    localparam int unsigned JB = walk_idx(STATE_TRITS, Half, i + 1);
    assign mixed[i] = mix_trit(state_q[JA], state_q[JB]);
  end

  assign pos_idx     = IdxW'(cmd_i.pos[PosW-1:0]);
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign trit_o      = trit_q;

  always_comb begin
    fsm_d       = fsm_q;
    rounds_d    = rounds_q;
    state_d     = state_q;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    trit_d      = trit_q;
    case (fsm_q)
      CORE_RUN: begin
        if (cmd_avail_i && (cmd_i.op != OP_SQUEEZE || out_free)) begin
          pop_o = 1'b1;
          case (cmd_i.op)
            OP_ABSORB: begin
              state_d[pos_idx] = cmd_i.trit;
            end
            OP_SQUEEZE: begin
              out_valid_d = 1'b1;
              trit_d      = state_q[pos_idx];
            end
            OP_CLEAR: begin
              for (int k = 0; k < STATE_TRITS; k++) begin
                state_d[k] = TRIT_ZERO;
              end
            end
            default: begin
              pop_o = 1'b1;
            end
          endcase
          // zero rounds leaves the state as is
          if (cmd_i.last && round_count_i != '0) begin
            fsm_d    = CORE_ROUND;
            rounds_d = round_count_i;
          end
        end
      end
      CORE_ROUND: begin
        state_d  = mixed;
        rounds_d = rounds_q - 1'b1;
        if (rounds_q == 7'd1) begin
          fsm_d = CORE_RUN;
        end
      end
      default: begin
        fsm_d = CORE_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= CORE_RUN;
      rounds_q    <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < STATE_TRITS; k++) begin
        state_q[k] <= TRIT_ZERO;
      end
    end else begin
      fsm_q       <= fsm_d;
      rounds_q    <= rounds_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    trit_q <= trit_d;
  end

endmodule

// ===== rtl/tsh_checker.sv =====
// port-level assertions for the ternary sponge hash, bound to the top level
module tsh_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic [1:0]        operation_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic signed [1:0] trit_out_o
);
  import tsh_pkg::*;

  logic [3:0] pending_q;
  logic       sq_in, res_out;

  assign sq_in   = in_valid_i && in_ready_o && (operation_i == OP_SQUEEZE);
  assign res_out = out_valid_o && out_ready_i;

  // squeezes accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + {3'b000, sq_in} - {3'b000, res_out};
    end
  end

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result offered during reset");

  a_result_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != '0)
    else $error("result offered with no squeeze outstanding");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(trit_out_o))
    else $error("stalled result dropped or changed");

  a_no_spare_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_out && pending_q == 4'd1 && !sq_in |=> !out_valid_o)
    else $error("result offered beyond the squeezes requested");

endmodule

bind ternary_sponge_hash tsh_checker u_tsh_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .operation_i(operation_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .trit_out_o (trit_out_o)
);
